// ===== design/wvwm_pkg.sv =====
// Package for the wavelet vector watermark bit block.
// Holds pipeline sizes, configuration register indexes and the lane stage record.
// No dependencies.
`default_nettype none

package wvwm_pkg;

    localparam int COEFF_W     = 32;
    localparam int STRENGTH_W  = 16;
    localparam int PROD_W      = COEFF_W + STRENGTH_W;
    localparam int REM_W       = 64;
    localparam int QUO_W       = 17;
    localparam int VOTE_W      = QUO_W + 1;
    localparam int CFG_IDX_W   = 8;

    // Lane stages: two sorting layers, product, ten quotient steps,
    // post-processing, seventeen belief steps.
    localparam int SORT_STAGES = 2;
    localparam int Q_STEPS     = 10;
    localparam int B_STEPS     = 17;
    localparam int PROD_STAGE  = SORT_STAGES;
    localparam int POST_STAGE  = PROD_STAGE + Q_STEPS + 1;
    localparam int NL          = POST_STAGE + B_STEPS + 1;
    localparam int CNT_W       = $clog2(NL + 2);

    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 8'd0,
        CFG_STRENGTH = 8'd1
    } t_cfg_idx;

    typedef enum logic {
        MODE_EMBED   = 1'b0,
        MODE_EXTRACT = 1'b1
    } t_mode;

    typedef logic [3:0][COEFF_W-1:0] t_vec;

    typedef struct packed {
        t_vec              c;     // coefficients in original order
        t_vec              v;     // sorted values
        logic [3:0][1:0]   p;     // original position of each sorted value
        logic              mark;
        logic              dz;    // zero step
        logic              odd;   // parity of the rounded distance
        logic [PROD_W-1:0] d;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  q;
    } t_lane_stage;

endpackage

`default_nettype wire

// ===== design/wvwm_lane.sv =====
// One vector lane: sorting network, step product, quotient pipeline,
// embedding and belief pipeline. Depends on wvwm_pkg.
`default_nettype none

module wvwm_lane (
    input  wire                                i_clk,
    input  wire  [wvwm_pkg::NL-1:0]            i_go,
    input  wire                                i_mode,
    input  wire  [wvwm_pkg::STRENGTH_W-1:0]    i_strength,
    input  wire  wvwm_pkg::t_vec               i_coeff,
    input  wire                                i_mark,
    output wvwm_pkg::t_vec                     o_coeff,
    output logic signed [wvwm_pkg::VOTE_W-1:0] o_vote,
    output logic                               o_mark
);
    import wvwm_pkg::*;

    t_lane_stage r_st [NL];
    t_lane_stage n_st [NL];

    // Compare-exchange, swapping only on strictly greater.
    function automatic t_lane_stage cswap(t_lane_stage s, int a, int b);
        logic [COEFF_W-1:0] tv;
        logic [1:0]         tp;
        if ($signed(s.v[a]) > $signed(s.v[b])) begin
            tv = s.v[a]; tp = s.p[a];
            s.v[a] = s.v[b]; s.p[a] = s.p[b];
            s.v[b] = tv; s.p[b] = tp;
        end
        return s;
    endfunction

    // One restoring division step against the divisor shifted left by sh.
    function automatic t_lane_stage dstep(t_lane_stage s, int sh);
        logic [REM_W-1:0] dsh;
        dsh = REM_W'(s.d) << sh;
        if (s.rem >= dsh) begin
            s.rem   = s.rem - dsh;
            s.q[sh] = 1'b1;
        end
        return s;
    endfunction

    // Post-processing: rounding, embedding and belief numerator.
    function automatic t_lane_stage post(t_lane_stage s, logic mode);
        logic                      up;
        logic [PROD_W:0]           e;
        logic signed [PROD_W+1:0]  x;
        logic signed [PROD_W-9:0]  chg;
        logic signed [PROD_W-7:0]  lo;
        logic signed [PROD_W-7:0]  hi;
        logic [COEFF_W-1:0]        slo;
        logic [COEFF_W-1:0]        shi;
        up = ({s.rem[REM_W-2:0], 1'b0} >= REM_W'(s.d));
        e  = up ? (PROD_W+1)'(s.d - s.rem[PROD_W-1:0])
                : (PROD_W+1)'(s.rem[PROD_W-1:0]);
        // Change towards the wanted parity, rounded to nearest, ties upward.
        x   = (s.q[0] != s.mark)
            ? $signed({2'b00, s.d}) - $signed({2'b00, s.rem[PROD_W-1:0]})
            : -$signed({2'b00, s.rem[PROD_W-1:0]});
        chg = (PROD_W-8)'((x + 512) >>> 10);
        lo  = (PROD_W-6)'($signed(s.v[1])) - (PROD_W-6)'(chg);
        hi  = (PROD_W-6)'($signed(s.v[2])) + (PROD_W-6)'(chg);
        // Saturate both moved coefficients to 32 bits.
        if (lo > (PROD_W-6)'(2147483647))            slo = 32'h7fff_ffff;
        else if (lo < (PROD_W-6)'(-2147483647 - 1))  slo = 32'h8000_0000;
        else                                          slo = lo[COEFF_W-1:0];
        if (hi > (PROD_W-6)'(2147483647))            shi = 32'h7fff_ffff;
        else if (hi < (PROD_W-6)'(-2147483647 - 1))  shi = 32'h8000_0000;
        else                                          shi = hi[COEFF_W-1:0];
        s.dz  = (s.d == '0);
        s.odd = s.q[0] ^ up;
        if (mode == MODE_EMBED && !s.dz) begin
            s.c[s.p[1]] = slo;
            s.c[s.p[2]] = shi;
        end
        s.rem = REM_W'(REM_W'(s.d) - REM_W'({e, 1'b0})) << 16;
        s.q   = '0;
        return s;
    endfunction

    // Next value of every stage.
    always_comb begin
        logic [COEFF_W-1:0] rng;
        logic [COEFF_W-1:0] mid;
        t_lane_stage        s;
        s   = '0;
        rng = '0;
        mid = '0;
        for (int k = 0; k < NL; k++) begin
            if (k == 0) begin
                s      = '0;
                s.c    = i_coeff;
                s.v    = i_coeff;
                s.mark = i_mark;
                for (int j = 0; j < 4; j++) s.p[j] = 2'(j);
                s = cswap(s, 0, 1);
                s = cswap(s, 2, 3);
            end else if (k == 1) begin
                s = cswap(r_st[0], 0, 2);
                s = cswap(s, 1, 3);
                s = cswap(s, 1, 2);
            end else if (k == PROD_STAGE) begin
                s     = r_st[k-1];
                rng   = s.v[3] - s.v[0];
                mid   = s.v[2] - s.v[1];
                s.d   = PROD_W'(rng) * PROD_W'(i_strength);
                s.rem = REM_W'(mid) << 9;
                s.q   = '0;
            end else if (k < POST_STAGE) begin
                s = dstep(r_st[k-1], POST_STAGE - 1 - k);
            end else if (k == POST_STAGE) begin
                s = post(r_st[k-1], i_mode);
            end else begin
                s = dstep(r_st[k-1], NL - 1 - k);
            end
            n_st[k] = s;
        end
    end

    // Stage registers load whenever the stage can move on.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NL; k++) begin
            if (i_go[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Lane result: coefficients and signed parity vote.
    always_comb begin
        o_coeff = r_st[NL-1].c;
        o_mark  = r_st[NL-1].mark;
        if (r_st[NL-1].dz)        o_vote = -VOTE_W'(65536);
        else if (r_st[NL-1].odd)  o_vote = VOTE_W'(r_st[NL-1].q);
        else                      o_vote = -VOTE_W'(r_st[NL-1].q);
    end

endmodule

`default_nettype wire

// ===== design/wavelet_vector_watermark_bit.sv =====
// Top level of the wavelet vector watermark bit block: row and column lanes,
// stage handshake and the vote merging output register.
// Depends on wvwm_pkg and wvwm_lane.
//
// Usage: one input word on the s_axis group carries the four row and four
// column coefficients in tdata (row 0 in the lowest bits) and the mark bit in
// tuser. Each word yields exactly one word on the m_axis group, in order.
// The cfg channel writes mode (index 0) and strength (index 1); it is always
// ready and must only be used while no word is in flight.
// Throughput is one word per clock while the receiver keeps m_axis_tready high. A
// word passes two sorting layers, the step product, ten quotient steps, a
// post-processing stage, seventeen belief-division steps and the output
// register on its way to m_axis_tvalid, the first of them loaded at the accepting edge itself.
// Up to 32 words are held in flight; every stage holds its word
// only while the one after it is occupied, so a stalled receiver fills the
// bubbles first and s_axis_tready drops only when all stages are full.
// Reset clears all valid flags, sets mode to embed and strength to 128.
`default_nettype none

module wavelet_vector_watermark_bit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input words.
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: row_coeff_0..3, col_coeff_0..3, 32 bits each, lowest first.
    input  wire  [8*wvwm_pkg::COEFF_W-1:0]      s_axis_tdata,
    // tuser: mark_bit.
    input  wire                                 s_axis_tuser,
    // Result words.
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // tdata: row_out_0..3, col_out_0..3, 32 bits each, lowest first.
    output logic [8*wvwm_pkg::COEFF_W-1:0]      m_axis_tdata,
    // tuser: decoded_bit.
    output logic                                m_axis_tuser,
    // Configuration writes.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [wvwm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [wvwm_pkg::STRENGTH_W-1:0]     i_cfg_data
);
    import wvwm_pkg::*;

    logic                      r_mode;
    logic [STRENGTH_W-1:0]     r_strength;
    logic [NL-1:0]             r_vld;
    logic [NL-1:0]             go;
    logic                      out_rdy;
    t_vec                      row_in, col_in, row_res, col_res;
    logic signed [VOTE_W-1:0]  row_vote, col_vote;
    logic signed [VOTE_W:0]    vote_sum;
    logic                      row_mark, col_mark;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_EMBED;
            r_strength <= STRENGTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                CFG_STRENGTH: r_strength <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // A stage may load when it is empty or its successor moves on.
    always_comb begin
        out_rdy    = !m_axis_tvalid || m_axis_tready;
        go[NL-1]   = !r_vld[NL-1] || out_rdy;
        for (int k = NL - 2; k >= 0; k--) begin
            go[k] = !r_vld[k] || go[k+1];
        end
    end
    assign s_axis_tready = go[0];

    // Valid flags of the stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (go[0]) r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < NL; k++) begin
                if (go[k]) r_vld[k] <= r_vld[k-1];
            end
            if (out_rdy) m_axis_tvalid <= r_vld[NL-1];
        end
    end

    // Split the input word into the two vectors.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            row_in[j] = s_axis_tdata[j*COEFF_W +: COEFF_W];
            col_in[j] = s_axis_tdata[(j+4)*COEFF_W +: COEFF_W];
        end
    end

    wvwm_lane u_row (
        .i_clk      (i_clk),
        .i_go       (go),
        .i_mode     (r_mode),
        .i_strength (r_strength),
        .i_coeff    (row_in),
        .i_mark     (s_axis_tuser),
        .o_coeff    (row_res),
        .o_vote     (row_vote),
        .o_mark     (row_mark)
    );

    wvwm_lane u_col (
        .i_clk      (i_clk),
        .i_go       (go),
        .i_mode     (r_mode),
        .i_strength (r_strength),
        .i_coeff    (col_in),
        .i_mark     (s_axis_tuser),
        .o_coeff    (col_res),
        .o_vote     (col_vote),
        .o_mark     (col_mark)
    );

    // Merge the two votes; a tie decides for one.
    assign vote_sum = (VOTE_W+1)'(row_vote) + (VOTE_W+1)'(col_vote);

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            m_axis_tdata <= {col_res, row_res};
            m_axis_tuser <= (r_mode == MODE_EXTRACT) ? !vote_sum[VOTE_W]
                                                     : (row_mark & col_mark);
        end
    end

endmodule

`default_nettype wire

// ===== design/wvwm_checker.sv =====
// Port-level checker for the wavelet vector watermark bit block, with bind.
// Depends on wvwm_pkg and the top level's ports.
`default_nettype none

module wvwm_port_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [8*wvwm_pkg::COEFF_W-1:0]    m_axis_tdata,
    input wire                              m_axis_tuser
);
    import wvwm_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Words accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(in_acc) - CNT_W'(out_acc);
        end
    end

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // No result without a word in flight.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_cnt != '0)
        else $error("result word without a matching input word");

    // A full block with a stalled receiver takes no more words.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CNT_W'(NL + 1) && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted beyond pipeline capacity");

    // An empty block is ready for input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> s_axis_tready && !m_axis_tvalid)
        else $error("empty block not ready");

endmodule

bind wavelet_vector_watermark_bit wvwm_port_checker u_wvwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/wvwm_checker.sv =====
// Checker for the wavelet vector watermark bit block: watches the input,
// result and configuration channels, predicts each result and compares it.
// Depends on wvwm_pkg.
`default_nettype none

module wvwm_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    input  wire                                i_in_ready,
    input  wire  [8*wvwm_pkg::COEFF_W-1:0]     i_in_data,
    input  wire                                i_in_mark,
    input  wire                                i_out_valid,
    input  wire                                i_out_ready,
    input  wire  [8*wvwm_pkg::COEFF_W-1:0]     i_out_data,
    input  wire                                i_out_bit,
    input  wire                                i_cfg_valid,
    input  wire                                i_cfg_ready,
    input  wire  [wvwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [wvwm_pkg::STRENGTH_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import wvwm_pkg::*;

    typedef struct {
        logic [8*COEFF_W-1:0] data;
        logic                 dec;
    } t_marked_word;

    t_marked_word    awaited_words[$];
    t_mode           cur_mode;
    logic [15:0]     cur_strength;

    // Sort four values ascending with their original positions.
    function automatic void sort_vec(ref longint v[4], ref int p[4]);
        int pairs[5][2];
        longint t;
        int q;
        pairs = '{'{0, 1}, '{2, 3}, '{0, 2}, '{1, 3}, '{1, 2}};
        for (int k = 0; k < 4; k++) p[k] = k;
        foreach (pairs[i]) begin
            if (v[pairs[i][0]] > v[pairs[i][1]]) begin
                t = v[pairs[i][0]]; q = p[pairs[i][0]];
                v[pairs[i][0]] = v[pairs[i][1]]; p[pairs[i][0]] = p[pairs[i][1]];
                v[pairs[i][1]] = t; p[pairs[i][1]] = q;
            end
        end
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Move the middle pair apart so the quantised spread carries the mark.
    function automatic void embed_mark(ref longint c[4], input logic mark);
        longint v[4];
        int p[4];
        longint unsigned d, n, m512;
        longint x, chg;
        v = c;
        sort_vec(v, p);
        d = longint'(v[3] - v[0]) * longint'(cur_strength);
        if (d == 0) return;
        m512 = 512 * longint'(v[2] - v[1]);
        n = m512 / d;
        if (n[0] != mark) n++;
        x = longint'(n * d) - longint'(m512) + 512;
        chg = x >>> 10;
        c[p[1]] = clamp32(v[1] - chg);
        c[p[2]] = clamp32(v[2] + chg);
    endfunction

    // Belief-weighted parity vote of one vector.
    function automatic longint parity_vote(longint c[4]);
        longint v[4];
        int p[4];
        longint unsigned d, mid, r, a, b, e, belief;
        v = c;
        sort_vec(v, p);
        d = longint'(v[3] - v[0]) * longint'(cur_strength);
        if (d == 0) return -65536;
        mid = v[2] - v[1];
        r = (1024 * mid + d) / (2 * d);
        a = 512 * mid;
        b = r * d;
        e = (a >= b) ? a - b : b - a;
        belief = ((d - 2 * e) << 16) / d;
        return r[0] ? longint'(belief) : -longint'(belief);
    endfunction

    function automatic t_marked_word predict_word(logic [8*COEFF_W-1:0] din, logic mark);
        longint row[4], col[4];
        t_marked_word w;
        for (int k = 0; k < 4; k++) begin
            row[k] = longint'($signed(din[k*COEFF_W +: COEFF_W]));
            col[k] = longint'($signed(din[(4+k)*COEFF_W +: COEFF_W]));
        end
        if (cur_mode == MODE_EMBED) begin
            embed_mark(row, mark);
            embed_mark(col, mark);
            w.dec = mark;
        end else begin
            w.dec = (parity_vote(row) + parity_vote(col) < 0) ? 1'b0 : 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
            w.data[k*COEFF_W +: COEFF_W]     = row[k][31:0];
            w.data[(4+k)*COEFF_W +: COEFF_W] = col[k][31:0];
        end
        return w;
    endfunction

    assign o_pending = awaited_words.size();

    // Track configuration, queue predictions and compare results.
    always @(posedge i_clk) begin
        t_marked_word w;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            cur_mode       <= MODE_EMBED;
            cur_strength   <= STRENGTH_RESET;
            o_fail_count   <= 0;
            o_result_count <= 0;
            awaited_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (awaited_words.size() == 0) begin
                    $error("result word with no prediction waiting");
                    errs++;
                end else begin
                    w = awaited_words.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (w.data[k*COEFF_W +: COEFF_W] !== i_out_data[k*COEFF_W +: COEFF_W]) begin
                            $error("%s_out_%0d expected %h actual %h",
                                   k < 4 ? "row" : "col", k % 4,
                                   w.data[k*COEFF_W +: COEFF_W],
                                   i_out_data[k*COEFF_W +: COEFF_W]);
                            errs++;
                        end
                    end
                    if (w.dec !== i_out_bit) begin
                        $error("decoded_bit expected %b actual %b", w.dec, i_out_bit);
                        errs++;
                    end
                end
                o_fail_count <= o_fail_count + errs;
            end
            if (i_in_valid && i_in_ready)
                awaited_words.push_back(predict_word(i_in_data, i_in_mark));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MODE) cur_mode <= t_mode'(i_cfg_data[0]);
                else if (i_cfg_index == CFG_STRENGTH) cur_strength <= i_cfg_data;
            end
        end
    end
endmodule

`default_nettype wire

// ===== sim/wavelet_vector_watermark_bit_tb.sv =====
// Testbench top for the wavelet vector watermark bit block: drives words and
// configuration writes with random idling and reports the verdict.
// Depends on wvwm_pkg, wvwm_checker and the block itself.
`default_nettype none

module wavelet_vector_watermark_bit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wvwm_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [8*COEFF_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [8*COEFF_W-1:0]    m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [STRENGTH_W-1:0]   i_cfg_data = '0;
    int                      fail_count, pending, result_count;
    longint                  cycle_count = 0;
    bit                      steady_phase = 1'b0;
    int                      words_sent = 0;

    always #1 i_clk = ~i_clk;

    wavelet_vector_watermark_bit u_top (.*);

    wvwm_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_mark(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_bit(m_axis_tuser),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Receiver stalls at random about 9 percent of the time outside the steady stretch.
    always @(posedge i_clk) begin
        m_axis_tready <= steady_phase || ($urandom_range(99) >= 9);
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coeff(int style);
        case ($urandom_range(style ? 7 : 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word and hold it until it is accepted; valid stays high
    // afterwards so that back-to-back words need no second assignment.
    task automatic send_word(logic [8*COEFF_W-1:0] data, logic mark);
        while (!steady_phase && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= mark;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (NL + 4) @(posedge i_clk);
    endtask

    // Random vector: clustered values give small spreads, raw values wide ones.
    function automatic logic [8*COEFF_W-1:0] random_vectors();
        logic [8*COEFF_W-1:0] d;
        logic [31:0] base;
        for (int v = 0; v < 2; v++) begin
            base = $urandom;
            for (int k = 0; k < 4; k++)
                d[(4*v+k)*COEFF_W +: COEFF_W] = ($urandom_range(1) == 0) ?
                    base + $urandom_range(1 << $urandom_range(20)) : pick_coeff(1);
        end
        return d;
    endfunction

    logic [15:0] strengths[6] = '{16'd0, 16'd1, 16'd128, 16'd65535, 16'd2048, 16'd37};

    initial begin
        logic [8*COEFF_W-1:0] d;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words in both modes at the reset strength, then one word per mode at zero strength.
        for (int m = 0; m < 2; m++) begin
            if (m == 1) begin
                drain();
                write_reg(CFG_MODE, MODE_EXTRACT);
            end
            send_word({8{32'h8000_0000}}, 1'b1);                 // zero range
            send_word({{4{32'h7fff_ffff}}, {2{32'h8000_0000}},
                       {2{32'h7fff_ffff}}}, 1'b0);
            send_word({32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0001, 32'h8000_0000,
                       32'd4, 32'd3, 32'd2, 32'd1}, 1'b1);        // saturation
            send_word({32'd0, 32'd5, 32'd5, 32'd10, 32'd1, 32'd1, 32'd2, 32'd2}, 1'b0);
            for (int i = 0; i < 6; i++) send_word(random_vectors(), i[0]);
        end
        drain();
        write_reg(CFG_STRENGTH, 16'd0);
        send_word(random_vectors(), 1'b1);                       // zero strength
        drain();
        write_reg(CFG_MODE, MODE_EMBED);
        send_word(random_vectors(), 1'b0);

        // Random phases across modes and strengths; one phase without idling.
        for (int ph = 0; ph < 16; ph++) begin
            drain();
            write_reg(CFG_MODE, t_mode'(ph[0]));
            write_reg(CFG_STRENGTH, (ph < 12) ? strengths[ph % 6] : 16'($urandom));
            steady_phase = (ph == 5);
            for (int i = 0; i < 100; i++) send_word(random_vectors(), $urandom_range(1));
            steady_phase = 1'b0;
        end
        drain();

        $display("Sent %0d words through both modes at six or more strengths,", words_sent);
        $display("and checked %0d result words.", result_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire
